[hw/rtl/trbs_pkg.sv]
// Package for the trace ring batch sender: shared constants, register map,
// send command type and back end state encoding.
// No dependencies.
package trbs_pkg;

	localparam int RING_SIZE_DEF = 1024;
	localparam int CHUNK_MAX_DEF = 64;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 10;
	localparam int THR_W  = 7;

	localparam logic [THR_W-1:0] BATCH_THRESHOLD_RST = 7'd32;
	localparam logic [THR_W-1:0] TICK_THRESHOLD      = 7'd1;

	// Configuration port: 32-bit data, one register at byte address 0.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_BATCH_THRESHOLD = '0;

	localparam int CMD_FIFO_DEPTH = 4;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic             link_ready;
	} send_cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_COPY,
		B_DRAIN,
		B_EMIT_RD,
		B_EMIT_LD
	} back_state_t;

endpackage

[hw/rtl/trbs_item_if.sv]
// Input channel of the trace ring batch sender: one trace byte or tick per word.
// Depends on trbs_pkg for field widths.
interface trbs_item_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [trbs_pkg::BYTE_W-1:0] data;
	logic                        first;
	logic [trbs_pkg::LEN_W-1:0]  msg_len;
	logic                        link_ready;

	modport source (output valid, op, data, first, msg_len, link_ready, input ready);
	modport sink (input valid, op, data, first, msg_len, link_ready, output ready);
endinterface

[hw/rtl/trbs_result_if.sv]
// Output channel of the trace ring batch sender: one chunk byte per word.
// Depends on trbs_pkg for field widths.
interface trbs_result_if;
	logic                        valid;
	logic                        ready;
	logic [trbs_pkg::BYTE_W-1:0] out_byte;
	logic                        chunk_last;

	modport source (output valid, out_byte, chunk_last, input ready);
	modport sink (input valid, out_byte, chunk_last, output ready);
endinterface

[hw/rtl/trbs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module trbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/trbs_cmd_fifo.sv]
// Short queue of send commands between the front and back ends.
// Depends on trbs_pkg for the command type.
module trbs_cmd_fifo #(
	parameter int DEPTH = trbs_pkg::CMD_FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  trbs_pkg::send_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output trbs_pkg::send_cmd_t pop_data,
	output logic                empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	trbs_pkg::send_cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/trbs_front.sv]
// Front end: takes input words, tracks message framing and admission, writes
// admitted bytes into the ring and queues send commands. Depends on trbs_pkg
// and trbs_item_if.
module trbs_front #(
	parameter int RING_SIZE = trbs_pkg::RING_SIZE_DEF,
	localparam int AW = $clog2(RING_SIZE)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	trbs_item_if.sink                     items,
	input  logic [trbs_pkg::THR_W-1:0]    batch_threshold,
	input  logic [AW-1:0]                 stored_count,
	input  logic                          back_idle,
	input  logic                          fifo_full,
	output logic                          cmd_push,
	output trbs_pkg::send_cmd_t           cmd,
	output logic                          ring_we,
	output logic [AW-1:0]                 ring_waddr,
	output logic [trbs_pkg::BYTE_W-1:0]   ring_wdata
);

	localparam int LW = (AW > trbs_pkg::LEN_W) ? AW : trbs_pkg::LEN_W;

	logic                          item_valid_s1;
	logic                          op_s1;
	logic [trbs_pkg::BYTE_W-1:0]   data_s1;
	logic                          first_s1;
	logic [trbs_pkg::LEN_W-1:0]    len_s1;
	logic                          lr_s1;

	logic [trbs_pkg::LEN_W-1:0]    left_q;
	logic [trbs_pkg::LEN_W-1:0]    left_n;
	logic                          admitted_q;
	logic                          admitted_n;
	logic [AW-1:0]                 wr_index_q;

	logic [AW-1:0]                 free_slots;
	logic                          len_fits;
	logic                          needs_push;
	logic                          write_en;
	logic                          is_admit;
	logic                          commit;
	logic                          accept;

	assign free_slots = AW'(RING_SIZE - 1) - stored_count;
	assign len_fits   = (LW'(len_s1) <= LW'(free_slots));

	always_comb begin
		needs_push    = 1'b0;
		write_en      = 1'b0;
		is_admit      = 1'b0;
		left_n        = left_q;
		admitted_n    = admitted_q;
		cmd.link_ready = lr_s1;
		cmd.threshold  = (batch_threshold == '0) ? trbs_pkg::TICK_THRESHOLD : batch_threshold;
		if (item_valid_s1) begin
			if (op_s1 == trbs_pkg::OP_TICK) begin
				// A tick inside an unfinished message is dropped.
				if (left_q == '0) begin
					needs_push    = 1'b1;
					cmd.threshold = trbs_pkg::TICK_THRESHOLD;
				end
			end else if (first_s1) begin
				if (len_s1 == '0) begin
					left_n     = '0;
					admitted_n = 1'b0;
				end else begin
					is_admit = 1'b1;
					write_en = len_fits;
					left_n   = len_s1 - 1'b1;
					if (left_n == '0) begin
						admitted_n = 1'b0;
						needs_push = 1'b1;
					end else begin
						admitted_n = len_fits;
					end
				end
			end else if (left_q != '0) begin
				write_en = admitted_q;
				left_n   = left_q - 1'b1;
				if (left_n == '0) begin
					admitted_n = 1'b0;
					needs_push = 1'b1;
				end
			end
		end
	end

	// Admission needs an exact stored count, so it waits until every queued
	// send has been carried out.
	assign commit = item_valid_s1 && !(needs_push && fifo_full) && !(is_admit && !back_idle);
	assign accept = items.valid && items.ready;

	assign items.ready = !item_valid_s1 || commit;
	assign cmd_push    = needs_push && commit;
	assign ring_we     = write_en && commit;
	assign ring_waddr  = wr_index_q;
	assign ring_wdata  = data_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= items.op;
			data_s1  <= items.data;
			first_s1 <= items.first;
			len_s1   <= items.msg_len;
			lr_s1    <= items.link_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			left_q        <= '0;
			admitted_q    <= 1'b0;
			wr_index_q    <= '0;
		end else begin
			if (accept) begin
				item_valid_s1 <= 1'b1;
			end else if (commit) begin
				item_valid_s1 <= 1'b0;
			end
			if (commit) begin
				left_q     <= left_n;
				admitted_q <= admitted_n;
			end
			if (ring_we) begin
				wr_index_q <= (wr_index_q == AW'(RING_SIZE - 1)) ? '0 : wr_index_q + 1'b1;
			end
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_full)
		else $error("send command pushed into a full queue");

	a_admit_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_admit) |-> back_idle)
		else $error("message admitted while a send was still outstanding");

endmodule

[hw/rtl/trbs_back.sv]
// Back end: carries out send commands, owns the stored count and read index,
// copies chunks from the ring into the hold buffer and emits held chunks.
// Depends on trbs_pkg, trbs_result_if and trbs_ram.
module trbs_back #(
	parameter int RING_SIZE = trbs_pkg::RING_SIZE_DEF,
	parameter int CHUNK_MAX = trbs_pkg::CHUNK_MAX_DEF,
	localparam int AW = $clog2(RING_SIZE)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	input  trbs_pkg::send_cmd_t         cmd,
	output logic                        cmd_pop,
	input  logic                        inc,
	output logic [AW-1:0]               ring_raddr,
	input  logic [trbs_pkg::BYTE_W-1:0] ring_rdata,
	output logic [AW-1:0]               stored_count,
	output logic                        idle,
	trbs_result_if.source               results
);

	localparam int HW   = $clog2(CHUNK_MAX);
	localparam int SW   = $clog2(CHUNK_MAX + 1);
	localparam int CMPW = (AW > 8) ? AW : 8;

	trbs_pkg::back_state_t state_q;
	trbs_pkg::back_state_t state_n;

	logic [AW-1:0]               count_q;
	logic [AW-1:0]               count_n;
	logic [AW-1:0]               rd_index_q;
	logic [AW-1:0]               rd_index_n;
	logic                        pending_q;
	logic                        pending_n;
	logic [SW-1:0]               held_size_q;
	logic [SW-1:0]               held_size_n;
	logic                        lr_q;
	logic                        lr_n;
	logic [HW-1:0]               copy_idx_q;
	logic [HW-1:0]               copy_idx_n;
	logic [HW-1:0]               emit_idx_q;
	logic [HW-1:0]               emit_idx_n;
	logic                        hw_valid_s1;
	logic [HW-1:0]               hw_idx_s1;

	logic                        out_valid_q;
	logic [trbs_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;
	logic                        out_free;
	logic                        out_load;
	logic                        emit_last;

	logic [trbs_pkg::BYTE_W-1:0] hold_rdata;
	logic                        take;
	logic [SW-1:0]               take_size;
	logic [AW-1:0]               sub;

	trbs_ram #(
		.WIDTH(trbs_pkg::BYTE_W),
		.DEPTH(CHUNK_MAX)
	) u_hold_ram (
		.clk  (clk),
		.we   (hw_valid_s1),
		.waddr(hw_idx_s1),
		.wdata(ring_rdata),
		.raddr(emit_idx_q),
		.rdata(hold_rdata)
	);

	assign ring_raddr   = rd_index_q;
	assign stored_count = count_q;
	assign idle         = (state_q == trbs_pkg::B_IDLE);

	assign take = !pending_q && (CMPW'(count_q) >= CMPW'(cmd.threshold));
	assign take_size = (CMPW'(count_q) > CMPW'(CHUNK_MAX)) ? SW'(CHUNK_MAX) : SW'(count_q);

	assign out_free  = !out_valid_q || results.ready;
	assign emit_last = (SW'(emit_idx_q) == held_size_q - 1'b1);

	always_comb begin
		state_n     = state_q;
		cmd_pop     = 1'b0;
		sub         = '0;
		rd_index_n  = rd_index_q;
		pending_n   = pending_q;
		held_size_n = held_size_q;
		lr_n        = lr_q;
		copy_idx_n  = copy_idx_q;
		emit_idx_n  = emit_idx_q;
		out_load    = 1'b0;
		case (state_q)
			trbs_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					lr_n    = cmd.link_ready;
					if (take) begin
						sub         = AW'(take_size);
						held_size_n = take_size;
						pending_n   = 1'b1;
						copy_idx_n  = '0;
						state_n     = trbs_pkg::B_COPY;
					end else if (pending_q && cmd.link_ready) begin
						emit_idx_n = '0;
						state_n    = trbs_pkg::B_EMIT_RD;
					end
				end
			end
			trbs_pkg::B_COPY: begin
				// One ring read per cycle; the hold write follows in the next cycle.
				rd_index_n = (rd_index_q == AW'(RING_SIZE - 1)) ? '0 : rd_index_q + 1'b1;
				copy_idx_n = copy_idx_q + 1'b1;
				if (SW'(copy_idx_q) == held_size_q - 1'b1) begin
					state_n = trbs_pkg::B_DRAIN;
				end
			end
			trbs_pkg::B_DRAIN: begin
				emit_idx_n = '0;
				state_n    = lr_q ? trbs_pkg::B_EMIT_RD : trbs_pkg::B_IDLE;
			end
			trbs_pkg::B_EMIT_RD: begin
				state_n = trbs_pkg::B_EMIT_LD;
			end
			trbs_pkg::B_EMIT_LD: begin
				if (out_free) begin
					out_load = 1'b1;
					if (emit_last) begin
						pending_n   = 1'b0;
						held_size_n = '0;
						state_n     = trbs_pkg::B_IDLE;
					end else begin
						emit_idx_n = emit_idx_q + 1'b1;
						state_n    = trbs_pkg::B_EMIT_RD;
					end
				end
			end
			default: begin
				state_n = trbs_pkg::B_IDLE;
			end
		endcase
		count_n = count_q + AW'(inc) - sub;
	end

	always_ff @(posedge clk) begin
		hw_idx_s1 <= copy_idx_q;
		lr_q      <= lr_n;
		copy_idx_q <= copy_idx_n;
		emit_idx_q <= emit_idx_n;
		if (out_load) begin
			out_byte_q <= hold_rdata;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trbs_pkg::B_IDLE;
			count_q     <= '0;
			rd_index_q  <= '0;
			pending_q   <= 1'b0;
			held_size_q <= '0;
			hw_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			count_q     <= count_n;
			rd_index_q  <= rd_index_n;
			pending_q   <= pending_n;
			held_size_q <= held_size_n;
			hw_valid_s1 <= (state_q == trbs_pkg::B_COPY);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_byte   = out_byte_q;
	assign results.chunk_last = out_last_q;

	a_busy_has_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == trbs_pkg::B_COPY || state_q == trbs_pkg::B_DRAIN ||
		 state_q == trbs_pkg::B_EMIT_RD || state_q == trbs_pkg::B_EMIT_LD) |-> pending_q)
		else $error("copy or emit running without a held chunk");

	a_held_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (held_size_q != '0))
		else $error("held chunk has zero size");

	a_last_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_last) |=> (!pending_q && state_q == trbs_pkg::B_IDLE && out_last_q))
		else $error("final chunk word did not release the hold buffer");

endmodule

[hw/rtl/trace_ring_batch_sender_unit.sv]
// Trace ring batch sender. A byte is written into the ring once the front end has registered
// and committed it; a first byte waits until all queued sends are done, a last byte for room
// in the send queue. A taken chunk is copied from the ring into the hold buffer, then emitted
// byte by byte through a read state and a load state that waits for the output; a new message
// waits for the back end. Reset clears states, counts, ring indexes and valid flags and sets
// batch_threshold to 32; ring and hold memories are not cleared and need no clearing pass.
module trace_ring_batch_sender_unit #(
	parameter int RING_SIZE = trbs_pkg::RING_SIZE_DEF,
	parameter int CHUNK_MAX = trbs_pkg::CHUNK_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	trbs_item_if.sink                       items,
	trbs_result_if.source                   results,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [trbs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [trbs_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [trbs_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int AW = $clog2(RING_SIZE);

	logic [trbs_pkg::THR_W-1:0]  batch_threshold_q;
	logic                        reg_sel;

	trbs_pkg::send_cmd_t         push_cmd;
	trbs_pkg::send_cmd_t         pop_cmd;
	logic                        cmd_push;
	logic                        cmd_pop;
	logic                        fifo_full;
	logic                        fifo_empty;

	logic                        ring_we;
	logic [AW-1:0]               ring_waddr;
	logic [trbs_pkg::BYTE_W-1:0] ring_wdata;
	logic [AW-1:0]               ring_raddr;
	logic [trbs_pkg::BYTE_W-1:0] ring_rdata;
	logic [AW-1:0]               stored_count;
	logic                        back_idle;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[trbs_pkg::CFG_ADDR_W-1:2] == trbs_pkg::REG_BATCH_THRESHOLD);
	assign prdata  = reg_sel ? trbs_pkg::CFG_DATA_W'(batch_threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_threshold_q <= trbs_pkg::BATCH_THRESHOLD_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			batch_threshold_q <= pwdata[trbs_pkg::THR_W-1:0];
		end
	end

	trbs_front #(
		.RING_SIZE(RING_SIZE)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.items          (items),
		.batch_threshold(batch_threshold_q),
		.stored_count   (stored_count),
		.back_idle      (back_idle && fifo_empty),
		.fifo_full      (fifo_full),
		.cmd_push       (cmd_push),
		.cmd            (push_cmd),
		.ring_we        (ring_we),
		.ring_waddr     (ring_waddr),
		.ring_wdata     (ring_wdata)
	);

	trbs_cmd_fifo #(
		.DEPTH(trbs_pkg::CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_data(push_cmd),
		.full     (fifo_full),
		.pop      (cmd_pop),
		.pop_data (pop_cmd),
		.empty    (fifo_empty)
	);

	trbs_ram #(
		.WIDTH(trbs_pkg::BYTE_W),
		.DEPTH(RING_SIZE)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	trbs_back #(
		.RING_SIZE(RING_SIZE),
		.CHUNK_MAX(CHUNK_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (fifo_empty),
		.cmd         (pop_cmd),
		.cmd_pop     (cmd_pop),
		.inc         (ring_we),
		.ring_raddr  (ring_raddr),
		.ring_rdata  (ring_rdata),
		.stored_count(stored_count),
		.idle        (back_idle),
		.results     (results)
	);

endmodule

[test/trace_ring_batch_sender_unit_test.sv]
`timescale 1ns / 100ps
// Testbench for trace_ring_batch_sender_unit: a table of directed words and then random
// message traffic, with every chunk byte checked against a built-in predictor.
// Depends on trbs_pkg, trbs_item_if, trbs_result_if and the unit itself.
module trace_ring_batch_sender_unit_test;

	localparam int SETTLE_CYCLES    = 400;
	localparam int LONG_HOLD_CYCLES = 800;
	localparam int N_DIRECTED       = 19;

	typedef logic [trbs_pkg::BYTE_W-1:0]     byte_t;
	typedef logic [trbs_pkg::LEN_W-1:0]      len_t;
	typedef logic [trbs_pkg::THR_W-1:0]      thr_t;
	typedef logic [trbs_pkg::CFG_DATA_W-1:0] cfg_word_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

	typedef struct packed {
		logic       op;
		byte_t      data;
		logic       first;
		len_t       len;
		logic       lr;
		row_check_t chk;
		byte_t      exp_b;
	} trace_row_t;

	typedef struct packed {
		byte_t b;
		logic  last;
	} out_word_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [trbs_pkg::CFG_ADDR_W-1:0] paddr;
	cfg_word_t                       pwdata;
	cfg_word_t                       prdata;
	logic                            pready;

	trbs_item_if   items_bus ();
	trbs_result_if results_bus ();

	trace_ring_batch_sender_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_bus),
		.results (results_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted state of the unit.
	byte_t       ring_model[$];
	byte_t       held_model[$];
	bit          held_valid;
	bit          msg_kept;
	int unsigned msg_left;
	thr_t        thr_model;

	out_word_t expected_out[$];
	int        mismatch_count;
	int        snd_burst;
	int        rcv_burst;
	bit        sender_fast;
	bit        long_hold_req;

	trace_row_t directed_rows [N_DIRECTED] = '{
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_BYTE, 8'hFF, 1'b1, 10'd0,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_BYTE, 8'hAA, 1'b0, 10'd5,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_BYTE, 8'h00, 1'b1, 10'd1,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b0, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b1, CHK_ONE,   8'h00},
		'{trbs_pkg::OP_BYTE, 8'hFF, 1'b1, 10'd1023, 1'b1, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_BYTE, 8'h55, 1'b0, 10'd0,    1'b0, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_BYTE, 8'h80, 1'b1, 10'd3,    1'b0, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_BYTE, 8'h7F, 1'b0, 10'd0,    1'b1, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_BYTE, 8'h01, 1'b0, 10'd0,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b1, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_BYTE, 8'h12, 1'b1, 10'd2,    1'b0, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_BYTE, 8'h34, 1'b0, 10'd0,    1'b0, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_BYTE, 8'hC3, 1'b1, 10'd1023, 1'b1, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_BYTE, 8'h00, 1'b1, 10'd0,    1'b1, CHK_NONE,  8'h00},
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b1, CHK_MODEL, 8'h00},
		'{trbs_pkg::OP_TICK, 8'h00, 1'b0, 10'd0,    1'b1, CHK_NONE,  8'h00}
	};

	function automatic void report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
	endfunction

	function automatic int next_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic trace_row_t make_row(input logic op, input byte_t data,
			input logic first, input len_t len, input logic lr);
		return '{op, data, first, len, lr, CHK_MODEL, 8'h00};
	endfunction

	// Take a chunk if none is held and enough bytes are stored, then emit it if the link is up.
	function automatic void attempt_send(input int unsigned thr, input logic lr,
			ref out_word_t words[$]);
		int unsigned take;
		if (thr == 0)
			thr = 1;
		if (!held_valid && ring_model.size() >= thr) begin
			take = (ring_model.size() > trbs_pkg::CHUNK_MAX_DEF) ?
				trbs_pkg::CHUNK_MAX_DEF : ring_model.size();
			repeat (take) held_model.push_back(ring_model.pop_front());
			held_valid = 1;
		end
		if (held_valid && lr) begin
			foreach (held_model[k])
				words.push_back('{held_model[k], k == held_model.size() - 1});
			held_model.delete();
			held_valid = 0;
		end
	endfunction

	function automatic void predict_chunk_output(input trace_row_t row, ref out_word_t words[$]);
		if (row.op == trbs_pkg::OP_TICK) begin
			if (msg_left == 0)
				attempt_send(trbs_pkg::TICK_THRESHOLD, row.lr, words);
			return;
		end
		if (row.first) begin
			if (row.len == 0) begin
				msg_left = 0;
				msg_kept = 0;
				return;
			end
			msg_left = row.len;
			msg_kept = int'(row.len) <= trbs_pkg::RING_SIZE_DEF - 1 - ring_model.size();
		end else if (msg_left == 0) begin
			return;
		end
		if (msg_kept)
			ring_model.push_back(row.data);
		msg_left--;
		if (msg_left != 0)
			return;
		msg_kept = 0;
		attempt_send(thr_model, row.lr, words);
	endfunction

	// All driving tasks start and end at a falling edge.
	task automatic send_word(input trace_row_t row);
		int        gap;
		out_word_t words[$];
		gap = sender_fast ? 0 : next_gap(snd_burst);
		if (gap != 0) begin
			items_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_bus.op         = row.op;
		items_bus.data       = row.data;
		items_bus.first      = row.first;
		items_bus.msg_len    = row.len;
		items_bus.link_ready = row.lr;
		items_bus.valid      = 1'b1;
		do @(posedge clk); while (!items_bus.ready);
		predict_chunk_output(row, words);
		case (row.chk)
			CHK_MODEL: foreach (words[k]) expected_out.push_back(words[k]);
			CHK_ONE:   expected_out.push_back('{row.exp_b, 1'b1});
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned len, input int lr_pct,
			input logic last_link_up);
		logic lr;
		for (int unsigned i = 0; i < len; i++) begin
			lr = ($urandom_range(0, 99) < lr_pct) || (last_link_up && i == len - 1);
			send_word(make_row(trbs_pkg::OP_BYTE, 8'($urandom), i == 0,
				(i == 0) ? len_t'(len) : len_t'($urandom), lr));
		end
	endtask

	task automatic random_messages(input int n, input int max_len, input int lr_pct);
		int kind;
		repeat (n) begin
			kind = $urandom_range(0, 15);
			if (kind < 10) begin
				send_message($urandom_range(1, max_len), lr_pct, 1'b0);
			end else if (kind < 12) begin
				send_word(make_row(trbs_pkg::OP_TICK, 8'($urandom), 1'($urandom),
					len_t'($urandom), 1'($urandom)));
			end else if (kind == 12) begin
				send_word(make_row(trbs_pkg::OP_BYTE, 8'($urandom), 1'b0, len_t'($urandom),
					1'($urandom)));
			end else if (kind == 13) begin
				send_word(make_row(trbs_pkg::OP_BYTE, 8'($urandom), 1'b1, '0, 1'($urandom)));
			end else begin
				// A message cut short; the next first byte starts over.
				send_word(make_row(trbs_pkg::OP_BYTE, 8'($urandom), 1'b1,
					len_t'($urandom_range(2, 1023)), 1'($urandom)));
				repeat ($urandom_range(0, 3))
					send_word(make_row(trbs_pkg::OP_BYTE, 8'($urandom), 1'b0,
						len_t'($urandom), 1'($urandom)));
			end
		end
	endtask

	// Close any open message, then tick with the link up until ring and hold buffer are empty.
	task automatic drain_ring();
		send_word(make_row(trbs_pkg::OP_BYTE, 8'($urandom), 1'b1, '0, 1'b1));
		while (ring_model.size() != 0 || held_valid)
			send_word(make_row(trbs_pkg::OP_TICK, 8'($urandom), 1'b0, len_t'($urandom),
				1'b1));
	endtask

	task automatic let_block_settle();
		items_bus.valid = 1'b0;
		while (expected_out.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_access(input logic wr, input cfg_word_t wdata,
			output cfg_word_t rdata);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {trbs_pkg::REG_BATCH_THRESHOLD, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_threshold(input thr_t value);
		cfg_word_t rd;
		let_block_settle();
		reg_access(1'b1, cfg_word_t'(value), rd);
		thr_model = value;
		reg_access(1'b0, '0, rd);
		if (rd !== cfg_word_t'(value))
			report_mismatch("batch_threshold readback", value, rd);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("trace_ring_batch_sender_unit_test failed");
		$finish;
	end

	// Receiver: random ready gaps, plus one long hold-off when asked for.
	initial begin
		int gap;
		results_bus.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				results_bus.ready = 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold_req = 0;
			end
			gap = next_gap(rcv_burst);
			if (gap != 0) begin
				results_bus.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			results_bus.ready = 1'b1;
			do @(posedge clk); while (!results_bus.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		out_word_t due;
		if (arst_n && results_bus.valid && results_bus.ready) begin
			if (expected_out.size() == 0) begin
				report_mismatch("chunk word with nothing due", '0, results_bus.out_byte);
			end else begin
				due = expected_out.pop_front();
				if (results_bus.out_byte !== due.b)
					report_mismatch("out_byte", due.b, results_bus.out_byte);
				if (results_bus.chunk_last !== due.last)
					report_mismatch("chunk_last", due.last, results_bus.chunk_last);
			end
		end
	end

	initial begin
		cfg_word_t rd;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		items_bus.valid      = 1'b0;
		items_bus.op         = trbs_pkg::OP_BYTE;
		items_bus.data       = '0;
		items_bus.first      = 1'b0;
		items_bus.msg_len    = '0;
		items_bus.link_ready = 1'b0;
		thr_model            = trbs_pkg::BATCH_THRESHOLD_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		reg_access(1'b0, '0, rd);
		if (rd !== cfg_word_t'(trbs_pkg::BATCH_THRESHOLD_RST))
			report_mismatch("batch_threshold after reset", trbs_pkg::BATCH_THRESHOLD_RST, rd);

		foreach (directed_rows[i])
			send_word(directed_rows[i]);

		set_threshold(7'd1);
		random_messages(10, 8, 70);
		drain_ring();

		// A threshold of zero acts as one.
		set_threshold(7'd0);
		random_messages(6, 6, 50);
		drain_ring();

		set_threshold(7'd64);
		random_messages(3, 40, 60);
		drain_ring();

		// The receiver holds off while words keep coming, so the unit backs up to its input.
		set_threshold(7'd4);
		long_hold_req = 1;
		sender_fast   = 1;
		random_messages(8, 10, 100);
		sender_fast   = 0;
		drain_ring();

		set_threshold(7'($urandom_range(2, 63)));
		random_messages(5, 12, 70);
		drain_ring();

		let_block_settle();
		if (mismatch_count == 0)
			$display("trace_ring_batch_sender_unit_test passed");
		else
			$display("trace_ring_batch_sender_unit_test failed");
		$finish;
	end

endmodule

[trace_ring_batch_sender_unit.f]
hw/rtl/trbs_pkg.sv
hw/rtl/trbs_item_if.sv
hw/rtl/trbs_result_if.sv
hw/rtl/trbs_ram.sv
hw/rtl/trbs_cmd_fifo.sv
hw/rtl/trbs_front.sv
hw/rtl/trbs_back.sv
hw/rtl/trace_ring_batch_sender_unit.sv
test/trace_ring_batch_sender_unit_test.sv
